/* rtl/hidk_pkg.sv */
// shared types, constants and usage-code map for the hid report to key event block
package hidk_pkg;

   localparam int MAX_SLOTS         = 6;
   localparam int KEY_SLOTS_DEFAULT = 6;

   localparam logic [7:0] SHIFT_MASK = 8'h22;
   localparam logic [5:0] SHIFT_KEY  = 6'h37;

   localparam logic [7:0] USAGE_A      = 8'h04;
   localparam logic [7:0] USAGE_Z      = 8'h1D;
   localparam logic [7:0] USAGE_1      = 8'h1E;
   localparam logic [7:0] USAGE_9      = 8'h26;
   localparam logic [7:0] USAGE_0      = 8'h27;
   localparam logic [7:0] USAGE_ENTER  = 8'h28;
   localparam logic [7:0] USAGE_ESC    = 8'h29;
   localparam logic [7:0] USAGE_BKSP   = 8'h2A;
   localparam logic [7:0] USAGE_SPACE  = 8'h2C;
   localparam logic [7:0] USAGE_MINUS  = 8'h2D;
   localparam logic [7:0] USAGE_SEMI   = 8'h33;
   localparam logic [7:0] USAGE_COMMA  = 8'h36;
   localparam logic [7:0] USAGE_PERIOD = 8'h37;
   localparam logic [7:0] USAGE_SLASH  = 8'h38;
   localparam logic [7:0] USAGE_RIGHT  = 8'h4F;
   localparam logic [7:0] USAGE_LEFT   = 8'h50;
   localparam logic [7:0] USAGE_DOWN   = 8'h51;
   localparam logic [7:0] USAGE_UP     = 8'h52;

   localparam logic [7:0] KEY_A_BASE = 8'h11;
   localparam logic [7:0] KEY_1_BASE = 8'h01;

   typedef struct packed {
      logic       valid;
      logic [5:0] key;
   } map_type;

   typedef struct packed {
      logic       rel_valid;
      logic [5:0] rel_key;
      logic       prs_valid;
      logic [5:0] prs_key;
   } lane_result_type;

   function automatic map_type map_usage(input logic [7:0] code);
      map_type    m;
      logic [7:0] sum;
      m.valid = 1'b1;
      m.key   = '0;
      sum     = '0;
      if (code >= USAGE_A && code <= USAGE_Z) begin
         sum   = KEY_A_BASE + (code - USAGE_A);
         m.key = sum[5:0];
      end else if (code >= USAGE_1 && code <= USAGE_9) begin
         sum   = KEY_1_BASE + (code - USAGE_1);
         m.key = sum[5:0];
      end else begin
         unique case (code)
            USAGE_0:      m.key = 6'h00;
            USAGE_ENTER:  m.key = 6'h30;
            USAGE_ESC:    m.key = 6'h32;
            USAGE_BKSP:   m.key = 6'h2D;
            USAGE_SPACE:  m.key = 6'h2F;
            USAGE_MINUS:  m.key = 6'h0D;
            USAGE_SEMI:   m.key = 6'h0B;
            USAGE_COMMA:  m.key = 6'h0C;
            USAGE_PERIOD: m.key = 6'h0E;
            USAGE_SLASH:  m.key = 6'h0F;
            USAGE_RIGHT:  m.key = 6'h2E;
            USAGE_LEFT:   m.key = 6'h2D;
            USAGE_DOWN:   m.key = 6'h2C;
            USAGE_UP:     m.key = 6'h2B;
            default:      m.valid = 1'b0;
         endcase
      end
      return m;
   endfunction

endpackage

/* rtl/hid_report_to_key_events.sv */
// top level: boot-keyboard report to key-matrix press and release items
// Each accepted report is compared combinationally with the held report by one lane per key
// slot; the shift change, releases and presses found are loaded into a pending event set that
// a serializer drains at one event per cycle, while the output is not stalled, into an output
// register. The first event of a report passes the pending event set register and then the
// output register. The next report waits on the input while the events of the current one,
// at most 1 + 2*KEY_SLOTS = 13, drain, and is taken in the cycle the last of them leaves the
// event set. Reports that cause no event are absorbed without output, one per cycle. No reset
// sweep: the block is ready as soon as reset is released.
module hid_report_to_key_events #(
   parameter int KEY_SLOTS = hidk_pkg::KEY_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // modifier_bits, key_slot_0 .. key_slot_5
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // is_press, matrix_key, zero pad
   output logic        rsp_tlast    // last_of_run
);
   import hidk_pkg::*;

   logic [KEY_SLOTS-1:0][7:0]         prev_ff, prev_in;
   logic                              shift_ff, shift_in;
   logic [KEY_SLOTS-1:0][7:0]         cur_all;
   lane_result_type [KEY_SLOTS-1:0]   lanes;
   logic                              shift_now;
   logic                              load;
   logic                              load_ok;

   always_comb begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
         cur_all[i] = req_tdata[8 + 8 * i +: 8];
      end
      shift_now  = (req_tdata[7:0] & SHIFT_MASK) != '0;
      req_tready = load_ok && !reset;
      load       = req_tvalid && req_tready;
      prev_in    = load ? cur_all : prev_ff;
      shift_in   = load ? shift_now : shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         shift_ff <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         shift_ff <= shift_in;
      end
   end

   for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
      hidk_lane #(.KEY_SLOTS(KEY_SLOTS)) u_lane (
         .cur_code  (cur_all[g]),
         .prev_code (prev_ff[g]),
         .cur_all   (cur_all),
         .prev_all  (prev_ff),
         .result    (lanes[g])
      );
   end

   hidk_merge #(.KEY_SLOTS(KEY_SLOTS)) u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .shift_event (shift_now != shift_ff),
      .shift_press (shift_now),
      .lanes       (lanes),
      .load_ok     (load_ok),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

/* rtl/hidk_lane.sv */
// one key slot: release and press detection against the other report
module hidk_lane #(
   parameter int KEY_SLOTS = hidk_pkg::KEY_SLOTS_DEFAULT
) (
   input  logic [7:0]                  cur_code,
   input  logic [7:0]                  prev_code,
   input  logic [KEY_SLOTS-1:0][7:0]   cur_all,
   input  logic [KEY_SLOTS-1:0][7:0]   prev_all,
   output hidk_pkg::lane_result_type   result
);
   import hidk_pkg::*;

   logic    prev_in_cur;
   logic    cur_in_prev;
   map_type prev_map;
   map_type cur_map;

   always_comb begin
      prev_in_cur = 1'b0;
      cur_in_prev = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
         if (cur_all[j] == prev_code) prev_in_cur = 1'b1;
         if (prev_all[j] == cur_code) cur_in_prev = 1'b1;
      end
      prev_map = map_usage(prev_code);
      cur_map  = map_usage(cur_code);

      result.rel_valid = (prev_code != '0) && !prev_in_cur && prev_map.valid;
      result.rel_key   = prev_map.key;
      result.prs_valid = (cur_code != '0) && !cur_in_prev && cur_map.valid;
      result.prs_key   = cur_map.key;
   end

endmodule

/* rtl/hidk_merge.sv */
// merge of lane results into a pending event set and serial event output
module hidk_merge #(
   parameter int KEY_SLOTS = hidk_pkg::KEY_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic                              shift_event,
   input  logic                              shift_press,
   input  hidk_pkg::lane_result_type [KEY_SLOTS-1:0] lanes,
   output logic                              load_ok,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // is_press, matrix_key[6:1], zero pad
   output logic                              rsp_tlast   // last_of_run
);
   import hidk_pkg::*;

   localparam int EV = 1 + 2 * KEY_SLOTS;

   logic [EV-1:0]       pend_ff, pend_in;
   logic [EV-1:0][5:0]  key_ff, key_in;
   logic                shift_press_ff, shift_press_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_press_ff, rsp_press_in;
   logic [5:0]          rsp_key_ff, rsp_key_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [EV-1:0]       low;
   logic [EV-1:0]       rest;
   logic [EV-1:0]       new_mask;
   logic [5:0]          sel_key;
   logic                sel_press;
   logic                out_free;
   logic                emit;

   always_comb begin
      low       = pend_ff & (~pend_ff + {{(EV-1){1'b0}}, 1'b1});
      rest      = pend_ff & ~low;
      sel_key   = '0;
      for (int i = 0; i < EV; i++) begin
         if (low[i]) sel_key = sel_key | key_ff[i];
      end
      sel_press = low[0] ? shift_press_ff : (low[EV-1 -: KEY_SLOTS] != '0);
      out_free  = !rsp_valid_ff || rsp_tready;
      emit      = (pend_ff != '0) && out_free;
      load_ok   = (pend_ff == '0) || (emit && (rest == '0));

      new_mask  = '0;
      key_in    = key_ff;
      new_mask[0] = shift_event;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         new_mask[1 + i]             = lanes[i].rel_valid;
         new_mask[1 + KEY_SLOTS + i] = lanes[i].prs_valid;
      end

      pend_in        = pend_ff;
      shift_press_in = shift_press_ff;
      if (load) begin
         pend_in        = new_mask;
         shift_press_in = shift_press;
         key_in[0]      = SHIFT_KEY;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            key_in[1 + i]             = lanes[i].rel_key;
            key_in[1 + KEY_SLOTS + i] = lanes[i].prs_key;
         end
      end else if (emit) begin
         pend_in = rest;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_press_in = rsp_press_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = emit;
         rsp_press_in = sel_press;
         rsp_key_in   = sel_key;
         rsp_last_in  = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff         <= key_in;
      shift_press_ff <= shift_press_in;
      rsp_press_ff   <= rsp_press_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_key_ff, rsp_press_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != '0 && !emit) |-> !load_ok)
      else $error("load allowed while events pending");

   a_last_frees_slot: assert property (@(posedge clock) disable iff (reset)
      (emit && rest == '0) |-> load_ok)
      else $error("final event does not free the event set");

   a_one_event_per_emit: assert property (@(posedge clock) disable iff (reset)
      (emit && !load) |=> ($countones(pend_ff) == $past($countones(pend_ff)) - 1))
      else $error("emit did not retire exactly one event");
`endif

endmodule

/* tb/hid_report_to_key_events_tb.sv */
// self-checking testbench for the boot-keyboard report to key event block
module hid_report_to_key_events_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hidk_pkg::*;

   localparam int SLOTS         = KEY_SLOTS_DEFAULT;
   localparam int IDLE_LIMIT    = 2000;
   localparam int TAIL_ITEMS    = 40;
   localparam int RANDOM_ITEMS  = 355;
   localparam logic [7:0] SPECIAL_CODES [0:12] = '{
      USAGE_ENTER, USAGE_ESC, USAGE_BKSP, USAGE_SPACE, USAGE_MINUS, USAGE_SEMI, USAGE_COMMA,
      USAGE_PERIOD, USAGE_SLASH, USAGE_RIGHT, USAGE_LEFT, USAGE_DOWN, USAGE_UP};

   typedef struct packed {
      logic [MAX_SLOTS-1:0][7:0] slot;
      logic [7:0]                modifier;
   } report_type;

   typedef struct packed {
      logic       is_press;
      logic [5:0] matrix_key;
      logic       last_of_run;
   } key_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;   // modifier_bits, key_slot_0 .. key_slot_5
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // is_press, matrix_key, zero pad
   logic        rsp_tlast;        // last_of_run

   report_type    reports_to_send[$];
   key_event_type pending_events[$];
   logic [7:0]    held_codes [MAX_SLOTS];
   logic          shift_down;
   int            mismatches = 0;
   int            send_gap = 0;
   int            stall_left = 0;
   int            idle_cycles = 0;
   logic          tail_phase;

   assign tail_phase = reports_to_send.size() < TAIL_ITEMS;

   hid_report_to_key_events #(.KEY_SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic usage_to_matrix(input logic [7:0] code, output logic [5:0] key);
      logic [7:0] wide;
      wide = '0;
      key  = '0;
      if (code >= USAGE_A && code <= USAGE_Z) begin
         wide = code - USAGE_A + KEY_A_BASE;
         key  = wide[5:0];
         return 1'b1;
      end
      if (code >= USAGE_1 && code <= USAGE_9) begin
         wide = code - USAGE_1 + KEY_1_BASE;
         key  = wide[5:0];
         return 1'b1;
      end
      case (code)
         USAGE_0:      key = 6'h00;
         USAGE_ENTER:  key = 6'h30;
         USAGE_ESC:    key = 6'h32;
         USAGE_BKSP:   key = 6'h2D;
         USAGE_SPACE:  key = 6'h2F;
         USAGE_MINUS:  key = 6'h0D;
         USAGE_SEMI:   key = 6'h0B;
         USAGE_COMMA:  key = 6'h0C;
         USAGE_PERIOD: key = 6'h0E;
         USAGE_SLASH:  key = 6'h0F;
         USAGE_RIGHT:  key = 6'h2E;
         USAGE_LEFT:   key = 6'h2D;
         USAGE_DOWN:   key = 6'h2C;
         USAGE_UP:     key = 6'h2B;
         default:      return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic logic code_in(input logic [7:0] code, input logic [7:0] codes [MAX_SLOTS]);
      for (int j = 0; j < SLOTS; j++)
         if (codes[j] == code) return 1'b1;
      return 1'b0;
   endfunction

   task automatic predict_events(input report_type r);
      logic [7:0]    now_codes [MAX_SLOTS];
      logic [5:0]    key;
      logic          shift_now;
      key_event_type ev;
      int            first;
      first = pending_events.size();
      for (int i = 0; i < MAX_SLOTS; i++) now_codes[i] = r.slot[i];
      shift_now = (r.modifier & SHIFT_MASK) != '0;
      if (shift_now != shift_down) begin
         ev = '{is_press: shift_now, matrix_key: SHIFT_KEY, last_of_run: 1'b0};
         pending_events.push_back(ev);
      end
      shift_down = shift_now;
      for (int i = 0; i < SLOTS; i++)
         if (held_codes[i] != '0 && !code_in(held_codes[i], now_codes)
             && usage_to_matrix(held_codes[i], key)) begin
            ev = '{is_press: 1'b0, matrix_key: key, last_of_run: 1'b0};
            pending_events.push_back(ev);
         end
      for (int i = 0; i < SLOTS; i++)
         if (now_codes[i] != '0 && !code_in(now_codes[i], held_codes)
             && usage_to_matrix(now_codes[i], key)) begin
            ev = '{is_press: 1'b1, matrix_key: key, last_of_run: 1'b0};
            pending_events.push_back(ev);
         end
      for (int i = 0; i < SLOTS; i++) held_codes[i] = now_codes[i];
      if (pending_events.size() > first)
         pending_events[pending_events.size()-1].last_of_run = 1'b1;
   endtask

   function automatic report_type rpt(input logic [7:0] m, s0, s1, s2, s3, s4, s5);
      report_type r;
      r.modifier = m;
      r.slot     = {s5, s4, s3, s2, s1, s0};
      return r;
   endfunction

   function automatic logic [7:0] pick_code();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return 8'($urandom_range(USAGE_A, USAGE_0));
      if (sel < 6) return SPECIAL_CODES[$urandom_range(0, 12)];
      if (sel < 8) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   // sender: gaps only between items so tvalid never drops mid-handshake
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= $urandom_range(0, 16);
         end else if (reports_to_send.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= reports_to_send.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor, predictor and watchdog
   always @(posedge clock) begin
      key_event_type want;
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) held_codes[i] = '0;
         shift_down  = 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_events.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item press=%0b key=%02h last=%0b", $realtime,
                        rsp_tdata[0], rsp_tdata[6:1], rsp_tlast);
            end else begin
               want = pending_events.pop_front();
               if (rsp_tdata[0] !== want.is_press) begin
                  mismatches++;
                  $display("%0t: is_press expected %0b actual %0b", $realtime,
                           want.is_press, rsp_tdata[0]);
               end
               if (rsp_tdata[6:1] !== want.matrix_key) begin
                  mismatches++;
                  $display("%0t: matrix_key expected %02h actual %02h", $realtime,
                           want.matrix_key, rsp_tdata[6:1]);
               end
               if (rsp_tlast !== want.last_of_run) begin
                  mismatches++;
                  $display("%0t: last_of_run expected %0b actual %0b", $realtime,
                           want.last_of_run, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) predict_events(report_type'(req_tdata));
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("hid_report_to_key_events_tb NOT OK");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      report_type prev;
      report_type nxt;
      int         n;
      // empty report, shift edges, full rollover, unmapped and duplicate codes
      reports_to_send.push_back(rpt(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      reports_to_send.push_back(rpt(8'h02, USAGE_A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      reports_to_send.push_back(rpt(8'h20, USAGE_A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      reports_to_send.push_back(rpt(8'hDD, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      reports_to_send.push_back(rpt(8'h22, USAGE_Z, USAGE_1, USAGE_9, USAGE_0, USAGE_ENTER,
                                    USAGE_ESC));
      reports_to_send.push_back(rpt(8'h00, USAGE_BKSP, USAGE_SPACE, USAGE_MINUS, USAGE_SEMI,
                                    USAGE_COMMA, USAGE_PERIOD));
      reports_to_send.push_back(rpt(8'h02, USAGE_SLASH, USAGE_RIGHT, USAGE_LEFT, USAGE_DOWN,
                                    USAGE_UP, 8'hFF));
      reports_to_send.push_back(rpt(8'h00, 8'h05, 8'h2B, 8'h05, 8'h00, 8'hFF, 8'h00));
      reports_to_send.push_back(rpt(8'h00, 8'h05, 8'h2B, 8'h05, 8'h00, 8'hFF, 8'h00));
      reports_to_send.push_back(rpt(8'h00, 8'h00, 8'h2B, 8'h00, 8'h00, 8'hFF, 8'h00));
      reports_to_send.push_back(rpt(8'h00, 8'h01, 8'h02, 8'h03, 8'h80, 8'hE0, 8'hFF));
      reports_to_send.push_back(rpt(8'h20, 8'hFF, 8'hE0, 8'h80, 8'h03, 8'h02, 8'h01));
      reports_to_send.push_back(rpt(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      reports_to_send.push_back(rpt(8'h00, USAGE_UP, USAGE_UP, 8'h00, 8'h00, 8'h00, USAGE_A));
      reports_to_send.push_back(rpt(8'h00, USAGE_A, 8'h00, 8'h00, 8'h00, 8'h00, USAGE_UP));
      reports_to_send.push_back(rpt(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      prev = reports_to_send[reports_to_send.size()-1];
      // typing sequences built from the previous report, with some noise
      repeat (RANDOM_ITEMS) begin
         nxt = prev;
         if ($urandom_range(0, 7) == 0) begin
            nxt.modifier = 8'($urandom_range(0, 255));
            for (int i = 0; i < MAX_SLOTS; i++) nxt.slot[i] = 8'($urandom_range(0, 255));
         end else begin
            n = $urandom_range(1, 3);
            repeat (n) nxt.slot[$urandom_range(0, MAX_SLOTS-1)] = pick_code();
            if ($urandom_range(0, 3) == 0) nxt.modifier = 8'($urandom_range(0, 255));
         end
         reports_to_send.push_back(nxt);
         prev = nxt;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (reports_to_send.size() != 0 || req_tvalid || pending_events.size() != 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("hid_report_to_key_events_tb OK");
      end else begin
         $display("hid_report_to_key_events_tb NOT OK");
      end
      $finish;
   end

endmodule
